FILE: hdl/ljpf_pkg.sv
// Shared constants, types and saturation helper for the Lennard-Jones pair force unit.
`default_nettype none
package ljpf_pkg;

  localparam int CoordW  = 24;
  localparam int CfgW    = 24;
  localparam int CfgIdxW = 2;
  localparam int OutW    = 32;
  localparam int DeltaW  = 25;
  localparam int MagW    = 24;
  localparam int SqW     = 48;
  localparam int S2W     = 48;
  localparam int R2W     = 50;
  localparam int Eps24W  = 29;
  localparam int NW      = 53;
  localparam int SrQw    = 42;
  localparam int AQw     = 61;
  localparam int Sr4W    = 52;
  localparam int Sr6W    = 62;
  localparam int P0W     = 56;
  localparam int GmW     = 63;
  localparam int BW      = 63;
  localparam int FW      = 72;
  localparam int MagSatW = 96;
  localparam int MulLat  = 3;

  // Item timing, counted from the divider inputs.
  localparam int TSr2 = SrQw;
  localparam int TSr4 = TSr2 + MulLat;
  localparam int TSr6 = TSr4 + MulLat;
  localparam int TP0  = TSr6 + MulLat;
  localparam int TPot = TP0 + MulLat;
  localparam int TA   = AQw;
  localparam int TB   = TA + MulLat;
  localparam int TF   = TB + MulLat;

  localparam logic [OutW-1:0] SatMax = 32'h7FFF_FFFF;
  localparam logic [OutW-1:0] SatMin = 32'h8000_0000;

  typedef enum logic [CfgIdxW-1:0] {
    REG_WELL_DEPTH     = 2'd0,
    REG_ZERO_CROSSING  = 2'd1,
    REG_MIN_SEPARATION = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic       valid;
    logic       special;
    logic       clamped;
    logic [2:0] dpos;
    logic [2:0] dzero;
  } side_t;

  function automatic logic [OutW-1:0] sat32(logic [MagSatW-1:0] mag, logic neg);
    logic [OutW-1:0] r;
    if (neg) begin
      r = (mag > MagSatW'(SatMin)) ? SatMin : (OutW'(0) - mag[OutW-1:0]);
    end else begin
      r = (mag > MagSatW'(SatMax)) ? SatMax : mag[OutW-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/ljpf_mul.sv
// Three-stage 64x64 unsigned multiplier built from 32x32 partial products.
`default_nettype none
module ljpf_mul (
  input  wire logic         clk_i,
  input  wire logic         en_i,
  input  wire logic [63:0]  a_i,
  input  wire logic [63:0]  b_i,
  output logic      [127:0] p_o
);

  logic [63:0]  ll_q, lh_q, hl_q, hh_q, ll2_q, hh2_q;
  logic [64:0]  mid_q;
  logic [127:0] p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ll_q  <= 64'(a_i[31:0]) * 64'(b_i[31:0]);
      lh_q  <= 64'(a_i[31:0]) * 64'(b_i[63:32]);
      hl_q  <= 64'(a_i[63:32]) * 64'(b_i[31:0]);
      hh_q  <= 64'(a_i[63:32]) * 64'(b_i[63:32]);
      mid_q <= 65'(lh_q) + 65'(hl_q);
      ll2_q <= ll_q;
      hh2_q <= hh_q;
      p_q   <= {hh2_q, ll2_q} + {31'b0, mid_q, 32'b0};
    end
  end

  assign p_o = p_q;

endmodule
`default_nettype wire

FILE: hdl/ljpf_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module ljpf_div #(
  parameter int DW = 50,
  parameter int QW = 42
) (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire logic [DW-1:0] rem_i,
  input  wire logic [QW-1:0] low_i,
  input  wire logic [DW-1:0] den_i,
  output logic      [QW-1:0] quo_o
);

  logic [DW-1:0] rem_q [QW];
  logic [DW-1:0] rem_d [QW];
  logic [DW-1:0] den_q [QW];
  logic [DW-1:0] den_d [QW];
  logic [QW-1:0] low_q [QW];
  logic [QW-1:0] low_d [QW];
  logic [QW-1:0] quo_q [QW];
  logic [QW-1:0] quo_d [QW];

  for (genvar s = 0; s < QW; s++) begin : g_st
    logic [DW-1:0] rem_in, den_in;
    logic [QW-1:0] low_in, quo_in;
    logic [DW:0]   trial;
    logic          ge;
    if (s == 0) begin : g_first
      assign rem_in = rem_i;
      assign den_in = den_i;
      assign low_in = low_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign den_in = den_q[s-1];
      assign low_in = low_q[s-1];
      assign quo_in = quo_q[s-1];
    end
    assign trial    = {rem_in, low_in[QW-1]};
    assign ge       = trial >= {1'b0, den_in};
    assign rem_d[s] = ge ? DW'(trial - {1'b0, den_in}) : trial[DW-1:0];
    assign den_d[s] = den_in;
    assign low_d[s] = {low_in[QW-2:0], 1'b0};
    assign quo_d[s] = {quo_in[QW-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < QW; s++) begin
        rem_q[s] <= rem_d[s];
        den_q[s] <= den_d[s];
        low_q[s] <= low_d[s];
        quo_q[s] <= quo_d[s];
      end
    end
  end

  assign quo_o = quo_q[QW-1];

endmodule
`default_nettype wire

FILE: hdl/ljpf_delay.sv
// Enabled delay line that keeps operands aligned with the pipeline.
`default_nettype none
module ljpf_delay #(
  parameter int W     = 8,
  parameter int DEPTH = 1
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         en_i,
  input  wire logic [W-1:0] d_i,
  output logic      [W-1:0] q_o
);

  logic [W-1:0] sh_q [DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) sh_q[i] <= '0;
    end else if (en_i) begin
      sh_q[0] <= d_i;
      for (int i = 1; i < DEPTH; i++) sh_q[i] <= sh_q[i-1];
    end
  end

  assign q_o = sh_q[DEPTH-1];

endmodule
`default_nettype wire

FILE: hdl/lennard_jones_pair_force_unit.sv
// Top level: Lennard-Jones 12-6 pair potential and force pipeline.
//
//  port group  dir  dtype           contents
//  s_axis      in   atom pair       tdata: first_x,y,z, second_x,y,z (24b each)
//  m_axis      out  pair result     tdata: force_x,y,z, pair_potential (32b each)
//                                   tuser: distance_clamped
//  cfg         in   register write  0 well_depth, 1 zero_crossing_distance,
//                                   2 min_separation
//
// One pair per cycle while the output is not stalled.
// Latency is set by the 61-stage per-axis divider plus two multiplies.
// Reset restores the default registers and empties the pipeline; no clearing pass.
// A stalled output freezes every stage, so the input stalls in the same cycle.
`default_nettype none
module lennard_jones_pair_force_unit (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // first_x, first_y, first_z, second_x, second_y, second_z
  input  wire logic [143:0]                    s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // force_x, force_y, force_z, pair_potential
  output logic      [127:0]                    m_axis_tdata,
  // distance_clamped
  output logic      [0:0]                      m_axis_tuser,
  input  wire logic                            cfg_we_i,
  input  wire logic [ljpf_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [ljpf_pkg::CfgW-1:0]       cfg_data_i
);

  import ljpf_pkg::*;

  localparam logic [Sr6W-1:0] OneQ32  = Sr6W'(64'h1_0000_0000);
  localparam logic [Sr6W-1:0] HalfQ32 = Sr6W'(64'h8000_0000);
  localparam logic [GmW-1:0]  OneQ32G = GmW'(64'h1_0000_0000);

  logic adv;

  logic [CfgW-1:0] well_depth_q, zero_crossing_q, min_sep_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      well_depth_q    <= 24'd12800;
      zero_crossing_q <= 24'd5120;
      min_sep_q       <= 24'd2560;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_WELL_DEPTH:     well_depth_q    <= cfg_data_i;
        REG_ZERO_CROSSING:  zero_crossing_q <= cfg_data_i;
        REG_MIN_SEPARATION: min_sep_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic out_valid_q;
  assign adv           = !out_valid_q || m_axis_tready;
  assign s_axis_tready = adv;

  // stage 1: deltas
  logic v1_q, v2_q, v3_q;
  logic signed [DeltaW-1:0] d_q [3];
  logic signed [DeltaW-1:0] d_d [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      d_d[c] = {s_axis_tdata[72+24*c+23], s_axis_tdata[72+24*c +: CoordW]}
             - {s_axis_tdata[24*c+23], s_axis_tdata[24*c +: CoordW]};
    end
  end

  // stage 2: squares, magnitudes, config products
  logic signed [2*DeltaW-1:0] sq_full [3];
  logic [SqW-1:0]    sq_q [3];
  logic [MagW-1:0]   mag_q [3];
  logic [MagW-1:0]   mag_d [3];
  logic [2:0]        dpos2_q, dzero2_q, dpos_d, dzero_d;
  logic [S2W-1:0]    s2_q, min2_q;
  logic [Eps24W-1:0] eps24_q;
  logic [CfgW-1:0]   minv;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sq_full[c] = d_q[c] * d_q[c];
      mag_d[c]   = d_q[c][DeltaW-1] ? MagW'(DeltaW'(0) - d_q[c]) : MagW'(d_q[c]);
      dzero_d[c] = (d_q[c] == '0);
      dpos_d[c]  = !d_q[c][DeltaW-1] && !dzero_d[c];
    end
    minv = (min_sep_q == '0) ? CfgW'(1) : min_sep_q;
  end

  // stage 3: clamped squared distance and force numerators
  logic [R2W-1:0] sum_d, r2_q;
  logic           clamp_d, clamp3_q;
  logic [NW-1:0]  n_q [3];
  logic [S2W-1:0] s2_3_q;
  logic [2:0]     dpos3_q, dzero3_q;

  assign sum_d   = R2W'(sq_q[0]) + R2W'(sq_q[1]) + R2W'(sq_q[2]);
  assign clamp_d = sum_d < R2W'(min2_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv) begin
      v1_q <= s_axis_tvalid;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        d_q[c]   <= d_d[c];
        sq_q[c]  <= sq_full[c][SqW-1:0];
        mag_q[c] <= mag_d[c];
        n_q[c]   <= NW'(eps24_q) * NW'(mag_q[c]);
      end
      dpos2_q  <= dpos_d;
      dzero2_q <= dzero_d;
      s2_q     <= S2W'(zero_crossing_q) * S2W'(zero_crossing_q);
      min2_q   <= S2W'(minv) * S2W'(minv);
      eps24_q  <= Eps24W'({well_depth_q, 4'b0}) + Eps24W'({well_depth_q, 3'b0});
      r2_q     <= clamp_d ? R2W'(min2_q) : sum_d;
      clamp3_q <= clamp_d;
      s2_3_q   <= s2_q;
      dpos3_q  <= dpos2_q;
      dzero3_q <= dzero2_q;
    end
  end

  // sideband travels beside the dividers
  side_t side_in, side_out;
  assign side_in.valid   = v3_q;
  assign side_in.special = {12'b0, s2_3_q} >= {r2_q, 10'b0};
  assign side_in.clamped = clamp3_q;
  assign side_in.dpos    = dpos3_q;
  assign side_in.dzero   = dzero3_q;

  ljpf_delay #(.W($bits(side_t)), .DEPTH(TF)) u_side (
    .clk_i, .rst_ni, .en_i(adv), .d_i(side_in), .q_o(side_out)
  );

  // sigma^2 / r2 and its powers
  logic [SrQw-1:0]   sr2, sr2_d3;
  logic [127:0]      p_sr4, p_sr6, p_p0, p_pot;
  logic [Sr6W-1:0]   sr6, pm, pm_d, sr6_a;
  logic [GmW-1:0]    gm, gm_b;
  logic              gpos, gpos_f, potneg, potneg_d;
  logic [OutW-1:0]   potv, potv_f;

  ljpf_div #(.DW(R2W), .QW(SrQw)) u_div_sr (
    .clk_i, .en_i(adv),
    .rem_i(R2W'(s2_3_q[S2W-1:10])),
    .low_i({s2_3_q[9:0], 32'b0}),
    .den_i(r2_q),
    .quo_o(sr2)
  );

  ljpf_delay #(.W(SrQw), .DEPTH(MulLat)) u_dl_sr2 (
    .clk_i, .rst_ni, .en_i(adv), .d_i(sr2), .q_o(sr2_d3)
  );

  ljpf_mul u_mul_sr4 (
    .clk_i, .en_i(adv), .a_i(64'(sr2)), .b_i(64'(sr2)), .p_o(p_sr4)
  );

  ljpf_mul u_mul_sr6 (
    .clk_i, .en_i(adv), .a_i(64'(p_sr4[Sr4W+31:32])), .b_i(64'(sr2_d3)), .p_o(p_sr6)
  );

  assign sr6    = p_sr6[Sr6W+31:32];
  assign potneg = sr6 < OneQ32;
  assign pm     = potneg ? (OneQ32 - sr6) : (sr6 - OneQ32);
  assign gpos   = sr6 >= HalfQ32;
  assign gm     = gpos ? ({sr6, 1'b0} - OneQ32G) : (OneQ32G - {sr6, 1'b0});

  ljpf_mul u_mul_p0 (
    .clk_i, .en_i(adv), .a_i(64'({well_depth_q, 2'b0})), .b_i(64'(sr6)), .p_o(p_p0)
  );

  ljpf_delay #(.W(Sr6W), .DEPTH(MulLat)) u_dl_pm (
    .clk_i, .rst_ni, .en_i(adv), .d_i(pm), .q_o(pm_d)
  );

  ljpf_delay #(.W(1), .DEPTH(TPot - TSr6)) u_dl_potneg (
    .clk_i, .rst_ni, .en_i(adv), .d_i(potneg), .q_o(potneg_d)
  );

  ljpf_mul u_mul_pot (
    .clk_i, .en_i(adv), .a_i(64'(p_p0[P0W+31:32])), .b_i(64'(pm_d)), .p_o(p_pot)
  );

  assign potv = sat32(p_pot[127:32], potneg_d);

  ljpf_delay #(.W(OutW), .DEPTH(TF - TPot)) u_dl_pot (
    .clk_i, .rst_ni, .en_i(adv), .d_i(potv), .q_o(potv_f)
  );

  ljpf_delay #(.W(Sr6W), .DEPTH(TA - TSr6)) u_dl_sr6 (
    .clk_i, .rst_ni, .en_i(adv), .d_i(sr6), .q_o(sr6_a)
  );

  ljpf_delay #(.W(GmW), .DEPTH(TB - TSr6)) u_dl_gm (
    .clk_i, .rst_ni, .en_i(adv), .d_i(gm), .q_o(gm_b)
  );

  ljpf_delay #(.W(1), .DEPTH(TF - TSr6)) u_dl_gpos (
    .clk_i, .rst_ni, .en_i(adv), .d_i(gpos), .q_o(gpos_f)
  );

  // per-axis force lanes
  logic [OutW-1:0] fv [3];

  for (genvar c = 0; c < 3; c++) begin : g_axis
    logic [AQw-1:0] a_q32;
    logic [127:0]   p_b, p_f;
    logic [BW-1:0]  b_sat;

    ljpf_div #(.DW(R2W), .QW(AQw)) u_div_a (
      .clk_i, .en_i(adv),
      .rem_i(R2W'(n_q[c][NW-1:29])),
      .low_i({n_q[c][28:0], 32'b0}),
      .den_i(r2_q),
      .quo_o(a_q32)
    );

    ljpf_mul u_mul_b (
      .clk_i, .en_i(adv), .a_i(64'(a_q32)), .b_i(64'(sr6_a)), .p_o(p_b)
    );

    assign b_sat = (p_b[127:95] != '0) ? {BW{1'b1}} : p_b[94:32];

    ljpf_mul u_mul_f (
      .clk_i, .en_i(adv), .a_i(64'(b_sat)), .b_i(64'(gm_b)), .p_o(p_f)
    );

    assign fv[c] = sat32(MagSatW'(p_f[FW+55:56]), side_out.dpos[c] == gpos_f);
  end

  // output register
  logic [OutW-1:0] frc_o [3];
  logic [OutW-1:0] pot_o;
  logic            eps_nz;
  logic [127:0]    tdata_q;
  logic            tuser_q;

  assign eps_nz = (well_depth_q != '0);

  always_comb begin
    pot_o = side_out.special ? (eps_nz ? SatMax : '0) : potv_f;
    for (int c = 0; c < 3; c++) begin
      if (!side_out.special) begin
        frc_o[c] = fv[c];
      end else if (!eps_nz || side_out.dzero[c]) begin
        frc_o[c] = '0;
      end else begin
        frc_o[c] = side_out.dpos[c] ? SatMin : SatMax;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= side_out.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      tdata_q <= {pot_o, frc_o[2], frc_o[1], frc_o[0]};
      tuser_q <= side_out.clamped;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = tdata_q;
  assign m_axis_tuser  = tuser_q;

  a_stall_holds_front: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(v1_q) && $stable(v3_q))
    else $error("front stages moved during output stall");

  a_stall_holds_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(side_out))
    else $error("sideband moved during output stall");

  a_transfer_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> v1_q)
    else $error("accepted transfer lost at stage one");

  a_bubble_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tvalid && adv |=> !v1_q)
    else $error("stage one valid without transfer");

endmodule
`default_nettype wire
